>>> src/iq_tone_generator_macros.svh
// ---------------------------------------------------------------------------
// iq_tone_generator assertion macros
// clocked assertion helpers shared by the tone generator top level
// ---------------------------------------------------------------------------
`ifndef IQ_TONE_GENERATOR_MACROS_SVH
`define IQ_TONE_GENERATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define IQTG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define IQTG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/iqtg_pkg.sv
// ---------------------------------------------------------------------------
// iqtg_pkg
// shared widths, register codes, state types, queue words and the
// quarter-wave sine entry function of the tone generator
// ---------------------------------------------------------------------------
package iqtg_pkg;

  localparam int CFG_W     = 24;
  localparam int PHASE_W   = 26;
  localparam int RED_SHIFT = PHASE_W - 2;
  localparam int MAG_W     = 12;
  localparam int CODE_W    = 14;

  localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;

  localparam logic REG_TONE_FREQ = 1'b0;
  localparam logic REG_RATE      = 1'b1;

  typedef enum logic [1:0] {
    FE_RUN,
    FE_LOAD,
    FE_REDUCE
  } fe_state_t;

  typedef enum logic [2:0] {
    BE_IDLE,
    BE_FOLD_HI,
    BE_FOLD_LO,
    BE_DIV,
    BE_ADDR,
    BE_ROM,
    BE_PUSH
  } be_state_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               restart;
  } fe_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] i_code;
    logic [CODE_W-1:0] q_code;
    logic              phase_restarted;
  } res_item_t;

  // shift-subtract quotient of two 64-bit words, elaboration only
  function automatic logic [63:0] div_u64(input logic [63:0] num,
                                          input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // floor(peak * sin(pi/2 * k / qn)) by a q60 odd series, elaboration only
  function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned k,
                                                    input int unsigned phase_bits,
                                                    input int unsigned peak);
    logic [127:0] prod;
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  term;
    logic [63:0]  sum;
    logic [63:0]  dv;
    int unsigned  s;
    int unsigned  qn;
    s  = phase_bits - 2;
    qn = 1 << s;
    if (k == 0) begin
      return '0;
    end
    if (k >= qn) begin
      return MAG_W'(peak);
    end
    prod = 128'(HALF_PI_Q60) * 128'(k);
    x    = 64'(prod >> s);
    prod = 128'(x) * 128'(x);
    x2   = 64'(prod >> 60);
    term = x;
    sum  = x;
    for (int n = 1; n <= 12; n++) begin
      prod = 128'(term) * 128'(x2);
      dv   = 64'((2 * n) * (2 * n + 1));
      term = div_u64(64'(prod >> 60), dv);
      if (n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    prod = 128'(sum) * 128'(peak);
    return MAG_W'(prod >> 60);
  endfunction

endpackage

>>> src/iqtg_fifo.sv
// ---------------------------------------------------------------------------
// iqtg_fifo
// small show-ahead word queue with push/full and pop/empty sides
// ---------------------------------------------------------------------------
module iqtg_fifo #(
  parameter int WIDTH   = 8,
  parameter int DEPTH_W = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] data_in,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] data_out,
  output logic             empty
);

  localparam int DEPTH = 1 << DEPTH_W;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH_W-1:0] wr_ptr;
  logic [DEPTH_W-1:0] rd_ptr;
  logic [DEPTH_W:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full     = (count == (DEPTH_W+1)'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign data_out = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/iqtg_front.sv
// ---------------------------------------------------------------------------
// iqtg_front
// configuration registers, phase accumulator modulo 4*rate and index
// restart; reduces the phase and tone step after every register write
// ---------------------------------------------------------------------------
module iqtg_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [iqtg_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          push,
  input  logic                          sample_request,
  output logic                          full,
  output logic                          q_push,
  output iqtg_pkg::fe_item_t            q_item,
  input  logic                          q_full,
  output logic [iqtg_pkg::CFG_W-1:0]    rate
);

  localparam int PW = iqtg_pkg::PHASE_W;
  localparam int DW = iqtg_pkg::PHASE_W + iqtg_pkg::CFG_W;
  localparam int CW = $clog2(iqtg_pkg::RED_SHIFT + 1);

  iqtg_pkg::fe_state_t state;
  iqtg_pkg::fe_state_t state_next;

  logic [iqtg_pkg::CFG_W-1:0] tone_freq;
  logic [iqtg_pkg::CFG_W-1:0] rate_reg;
  logic [PW-1:0] phase_raw;
  logic [PW-1:0] phase_red;
  logic [PW-1:0] tone_red;
  logic [PW-1:0] rem_p;
  logic [PW-1:0] rem_t;
  logic [DW-1:0] dstep;
  logic [CW-1:0] red_cnt;
  logic          started;

  logic [PW-1:0] modulus;
  logic [PW-1:0] rem_p_step;
  logic [PW-1:0] rem_t_step;
  logic [PW:0]   phase_sum;
  logic [PW-1:0] phase_adv;
  logic          accept;
  logic          step;
  logic          restart;

  assign rate    = (rate_reg == '0) ? iqtg_pkg::CFG_W'(1) : rate_reg;
  assign modulus = {rate, 2'b00};

  assign rem_p_step = ({(DW-PW)'(0), rem_p} >= dstep) ? rem_p - dstep[PW-1:0] : rem_p;
  assign rem_t_step = ({(DW-PW)'(0), rem_t} >= dstep) ? rem_t - dstep[PW-1:0] : rem_t;

  assign phase_sum = {1'b0, phase_red} + {1'b0, tone_red};
  assign phase_adv = (phase_sum >= {1'b0, modulus}) ? PW'(phase_sum - {1'b0, modulus})
                                                    : phase_sum[PW-1:0];
  assign restart   = (phase_red == '0) && started;

  always_comb begin
    state_next = state;
    unique case (state)
      iqtg_pkg::FE_RUN: begin
        state_next = iqtg_pkg::FE_RUN;
      end
      iqtg_pkg::FE_LOAD: begin
        state_next = iqtg_pkg::FE_REDUCE;
      end
      iqtg_pkg::FE_REDUCE: begin
        if (red_cnt == '0) begin
          state_next = iqtg_pkg::FE_RUN;
        end
      end
      default: begin
        state_next = iqtg_pkg::FE_RUN;
      end
    endcase
    if (cfg_write) begin
      state_next = iqtg_pkg::FE_LOAD;
    end
  end

  always_comb begin
    full           = (state != iqtg_pkg::FE_RUN) || q_full;
    accept         = push && !full;
    step           = accept && sample_request;
    q_push         = step;
    q_item.phase   = phase_red;
    q_item.restart = restart;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iqtg_pkg::FE_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tone_freq <= '0;
      rate_reg  <= iqtg_pkg::CFG_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        iqtg_pkg::REG_TONE_FREQ: tone_freq <= cfg_data;
        iqtg_pkg::REG_RATE:      rate_reg  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_raw <= '0;
      phase_red <= '0;
      tone_red  <= '0;
      started   <= 1'b0;
      red_cnt   <= '0;
    end else begin
      unique case (state)
        iqtg_pkg::FE_LOAD: begin
          red_cnt <= CW'(iqtg_pkg::RED_SHIFT);
        end
        iqtg_pkg::FE_REDUCE: begin
          red_cnt <= red_cnt - 1'b1;
          if (red_cnt == '0) begin
            phase_red <= rem_p_step;
            tone_red  <= rem_t_step;
          end
        end
        default: begin
          if (step) begin
            if (restart) begin
              phase_raw <= '0;
              phase_red <= '0;
              started   <= 1'b0;
            end else begin
              phase_raw <= phase_adv;
              phase_red <= phase_adv;
              started   <= 1'b1;
            end
          end
        end
      endcase
    end
  end

  // long reduction of phase and tone step by the shifted modulus
  always_ff @(posedge clk) begin
    if (state == iqtg_pkg::FE_LOAD) begin
      rem_p <= phase_raw;
      rem_t <= {(PW-iqtg_pkg::CFG_W)'(0), tone_freq};
      dstep <= {modulus, iqtg_pkg::RED_SHIFT'(0)};
    end else if (state == iqtg_pkg::FE_REDUCE) begin
      rem_p <= rem_p_step;
      rem_t <= rem_t_step;
      dstep <= dstep >> 1;
    end
  end

endmodule

>>> src/iqtg_back.sv
// ---------------------------------------------------------------------------
// iqtg_back
// angle divider, quadrant folding and quarter-wave table lookup that turn
// a queued phase into sine and cosine sign-magnitude codes
// ---------------------------------------------------------------------------
module iqtg_back #(
  parameter int PHASE_BITS = 12,
  parameter int PEAK_LEVEL = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  iqtg_pkg::fe_item_t         q_item,
  output logic                       q_pop,
  input  logic [iqtg_pkg::CFG_W-1:0] rate,
  input  logic                       out_full,
  output logic                       out_push,
  output iqtg_pkg::res_item_t        out_item
);

  localparam int PW    = iqtg_pkg::PHASE_W;
  localparam int QN    = 1 << (PHASE_BITS - 2);
  localparam int IDX_W = PHASE_BITS - 1;
  localparam int CNT_W = $clog2(PHASE_BITS);

  typedef logic [iqtg_pkg::MAG_W-1:0] rom_t [QN+1];

  function automatic rom_t build_rom();
    rom_t t;
    for (int k = 0; k <= QN; k++) begin
      t[k] = iqtg_pkg::quarter_sine(k, PHASE_BITS, PEAK_LEVEL);
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // {negative, table index} for one angle address
  function automatic logic [IDX_W:0] fold_addr(input logic [PHASE_BITS-1:0] addr);
    logic [1:0]       quad;
    logic [IDX_W-1:0] idx;
    quad = addr[PHASE_BITS-1:PHASE_BITS-2];
    idx  = quad[0] ? IDX_W'(QN) - {1'b0, addr[PHASE_BITS-3:0]}
                   : {1'b0, addr[PHASE_BITS-3:0]};
    return {quad[1] && (idx != '0), idx};
  endfunction

  iqtg_pkg::be_state_t state;
  iqtg_pkg::be_state_t state_next;

  logic [PW-1:0]              rem;
  logic [PHASE_BITS-1:0]      quo;
  logic [CNT_W-1:0]           div_cnt;
  logic                       restart;
  logic [IDX_W-1:0]           idx_s;
  logic [IDX_W-1:0]           idx_c;
  logic                       neg_s;
  logic                       neg_c;
  logic [iqtg_pkg::MAG_W-1:0] mag_s;
  logic [iqtg_pkg::MAG_W-1:0] mag_c;

  logic [PW-1:0]         rate_ext;
  logic [PW-1:0]         rate_x2;
  logic [PW-1:0]         rem_x2;
  logic [PHASE_BITS-1:0] addr_c;
  logic [IDX_W:0]        fold_s;
  logic [IDX_W:0]        fold_c;

  assign rate_ext = {2'b00, rate};
  assign rate_x2  = {1'b0, rate, 1'b0};
  assign rem_x2   = {rem[PW-3:0], 1'b0};
  assign addr_c   = quo + PHASE_BITS'(QN);
  assign fold_s   = fold_addr(quo);
  assign fold_c   = fold_addr(addr_c);

  always_comb begin
    state_next = state;
    unique case (state)
      iqtg_pkg::BE_IDLE: begin
        if (!q_empty) begin
          state_next = iqtg_pkg::BE_FOLD_HI;
        end
      end
      iqtg_pkg::BE_FOLD_HI: state_next = iqtg_pkg::BE_FOLD_LO;
      iqtg_pkg::BE_FOLD_LO: state_next = iqtg_pkg::BE_DIV;
      iqtg_pkg::BE_DIV: begin
        if (div_cnt == '0) begin
          state_next = iqtg_pkg::BE_ADDR;
        end
      end
      iqtg_pkg::BE_ADDR: state_next = iqtg_pkg::BE_ROM;
      iqtg_pkg::BE_ROM:  state_next = iqtg_pkg::BE_PUSH;
      iqtg_pkg::BE_PUSH: begin
        if (!out_full) begin
          state_next = iqtg_pkg::BE_IDLE;
        end
      end
      default: state_next = iqtg_pkg::BE_IDLE;
    endcase
  end

  always_comb begin
    q_pop                    = (state == iqtg_pkg::BE_IDLE) && !q_empty;
    out_push                 = (state == iqtg_pkg::BE_PUSH) && !out_full;
    out_item.i_code          = {neg_s, 1'b0, mag_s};
    out_item.q_code          = {neg_c, 1'b0, mag_c};
    out_item.phase_restarted = restart;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iqtg_pkg::BE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      iqtg_pkg::BE_IDLE: begin
        rem     <= q_item.phase;
        restart <= q_item.restart;
      end
      iqtg_pkg::BE_FOLD_HI: begin
        if (rem >= rate_x2) begin
          rem <= rem - rate_x2;
        end
      end
      iqtg_pkg::BE_FOLD_LO: begin
        if (rem >= rate_ext) begin
          rem <= rem - rate_ext;
        end
        quo     <= '0;
        div_cnt <= CNT_W'(PHASE_BITS - 1);
      end
      iqtg_pkg::BE_DIV: begin
        div_cnt <= div_cnt - 1'b1;
        if (rem_x2 >= rate_ext) begin
          rem <= rem_x2 - rate_ext;
          quo <= {quo[PHASE_BITS-2:0], 1'b1};
        end else begin
          rem <= rem_x2;
          quo <= {quo[PHASE_BITS-2:0], 1'b0};
        end
      end
      iqtg_pkg::BE_ADDR: begin
        neg_s <= fold_s[IDX_W];
        idx_s <= fold_s[IDX_W-1:0];
        neg_c <= fold_c[IDX_W];
        idx_c <= fold_c[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mag_s <= SINE_ROM[idx_s];
    mag_c <= SINE_ROM[idx_c];
  end

endmodule

>>> src/iq_tone_generator.sv
// ---------------------------------------------------------------------------
// iq_tone_generator
// quadrature tone generator: one sine/cosine sign-magnitude code pair per
// sample request
// ---------------------------------------------------------------------------
// Requests enter a front stage that steps the phase product modulo
// 4*rate and takes one request per cycle into a four-word queue unless
// full is high. A back stage turns each queued phase into a code pair with
// its restoring angle divider, which yields one address bit per cycle,
// followed by the quarter-wave table read; it takes the next phase only
// after the last pair is pushed. Results wait in a four-word output queue.
// After each register write the front is busy (full is high) while it
// reduces the phase product and tone step modulo the new 4*rate.
module iq_tone_generator #(
  parameter int PHASE_BITS = 12,
  parameter int PEAK_LEVEL = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [iqtg_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          push,
  input  logic                          sample_request,
  output logic                          full,
  input  logic                          pop,
  output logic                          empty,
  output logic [iqtg_pkg::CODE_W-1:0]   i_code,
  output logic [iqtg_pkg::CODE_W-1:0]   q_code,
  output logic                          phase_restarted
);

  `include "iq_tone_generator_macros.svh"

  iqtg_pkg::fe_item_t  fe_item;
  iqtg_pkg::fe_item_t  fe_head;
  iqtg_pkg::res_item_t res_item;
  iqtg_pkg::res_item_t res_head;

  logic                       fe_push;
  logic                       fe_full;
  logic                       fe_pop;
  logic                       fe_empty;
  logic                       res_push;
  logic                       res_full;
  logic [iqtg_pkg::CFG_W-1:0] rate;

  iqtg_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .push           (push),
    .sample_request (sample_request),
    .full           (full),
    .q_push         (fe_push),
    .q_item         (fe_item),
    .q_full         (fe_full),
    .rate           (rate)
  );

  iqtg_fifo #(
    .WIDTH   ($bits(iqtg_pkg::fe_item_t)),
    .DEPTH_W (2)
  ) u_fe_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (fe_push),
    .data_in  (fe_item),
    .full     (fe_full),
    .pop      (fe_pop),
    .data_out (fe_head),
    .empty    (fe_empty)
  );

  iqtg_back #(
    .PHASE_BITS (PHASE_BITS),
    .PEAK_LEVEL (PEAK_LEVEL)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (fe_empty),
    .q_item   (fe_head),
    .q_pop    (fe_pop),
    .rate     (rate),
    .out_full (res_full),
    .out_push (res_push),
    .out_item (res_item)
  );

  iqtg_fifo #(
    .WIDTH   ($bits(iqtg_pkg::res_item_t)),
    .DEPTH_W (2)
  ) u_res_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (res_push),
    .data_in  (res_item),
    .full     (res_full),
    .pop      (pop),
    .data_out (res_head),
    .empty    (empty)
  );

  assign i_code          = res_head.i_code;
  assign q_code          = res_head.q_code;
  assign phase_restarted = res_head.phase_restarted;

  `IQTG_ASSERT_NEXT(a_cfg_blocks_input, cfg_write, full, "input open right after a register write")
  `IQTG_ASSERT_NOW(a_fe_push_room, fe_push, !fe_full, "phase queue pushed while full")
  `IQTG_ASSERT_NOW(a_res_push_room, res_push, !res_full, "result queue pushed while full")

endmodule

>>> tb/sv/tb.sv
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the quadrature tone generator: a directed table,
// then randomized phases under several idling patterns; each result word is
// held to a typed row value or an in-bench sine/cosine phase-acc predictor
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   CFG_W         = iqtg_pkg::CFG_W;
  localparam int   CODE_W        = iqtg_pkg::CODE_W;
  localparam logic REG_TONE_FREQ = iqtg_pkg::REG_TONE_FREQ;
  localparam logic REG_RATE      = iqtg_pkg::REG_RATE;

  localparam int PHASE_BITS   = 12;
  localparam int PEAK_LEVEL   = 1024;
  localparam int QUARTER      = 1 << (PHASE_BITS - 2);
  localparam int NEG_BASE     = 8192;
  localparam int SETTLE       = 120;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 4000;
  localparam int PHASE_ITEMS  = 170;
  localparam int NUM_PHASES   = 8;
  localparam logic [63:0] HALF_PI_FX = 64'h1921FB54442D1846;

  typedef enum logic {ROW_REQUEST, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic               reg_sel;
    logic [CFG_W-1:0]   value;
    logic               req;
    logic               typed;
    logic [CODE_W-1:0]  i_val;
    logic [CODE_W-1:0]  q_val;
    logic               rst_val;
  } plan_row_t;

  typedef struct packed {
    logic [CODE_W-1:0] i_val;
    logic [CODE_W-1:0] q_val;
    logic              restarted;
  } iq_pair_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write = 1'b0;
  logic              cfg_index = 1'b0;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              push = 1'b0;
  logic              sample_request = 1'b0;
  logic              full;
  logic              pop = 1'b0;
  logic              empty;
  logic [CODE_W-1:0] i_code;
  logic [CODE_W-1:0] q_code;
  logic              phase_restarted;

  // typed expectation traveling with the offered word
  logic              given = 1'b0;
  logic [CODE_W-1:0] given_i = '0;
  logic [CODE_W-1:0] given_q = '0;
  logic              given_r = 1'b0;

  int unsigned stall_pct = 0;
  int unsigned idle_pct = 0;
  int unsigned hold_token = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned quiet = 0;
  int          mismatches = 0;

  int unsigned quarter_wave [0:QUARTER];
  logic [63:0] tone_step = 64'd0;
  logic [63:0] rate_reg = 64'd1;
  logic [63:0] phase_acc = 64'd0;
  logic        started = 1'b0;
  iq_pair_t    pending_pairs [$];

  localparam int PLAN_LEN = 30;
  plan_row_t dir_plan [0:PLAN_LEN-1] = '{
    '{ROW_REQUEST, REG_TONE_FREQ, 24'd0, 1'b1, 1'b1, 14'd0, 14'd1024, 1'b0},
    '{ROW_REQUEST, REG_TONE_FREQ, 24'd0, 1'b1, 1'b1, 14'd0, 14'd1024, 1'b1},
    '{ROW_REQUEST, REG_TONE_FREQ, 24'd0, 1'b0, 1'b0, 14'd0, 14'd0, 1'b0},
    '{ROW_REQUEST, REG_TONE_FREQ, 24'd0, 1'b1, 1'b1, 14'd0, 14'd1024, 1'b0},
    '{ROW_WRITE, REG_TONE_FREQ, 24'd1, 1'b0, 1'b0, 14'd0, 14'd0, 1'b0},
    '{ROW_WRITE, REG_RATE, 24'd4, 1'b0, 1'b0, 14'd0, 14'd0, 1'b0},
    '{ROW_REQUEST, REG_TONE_FREQ, 24'd0, 1'b1, 1'b1, 14'd0, 14'd1024, 1'b1},
    '{ROW_REQUEST, REG_TONE_FREQ, 24'd0, 1'b1, 1'b1, 14'd0, 14'd1024, 1'b0},
    '{ROW_REQUEST, REG_TONE_FREQ, 24'd0, 1'b1, 1'b1, 14'd1024, 14'd0, 1'b0},
    '{ROW_REQUEST, REG_TONE_FREQ, 24'd0, 1'b1, 1'b1, 14'd0, 14'd9216, 1'b0},
    '{ROW_REQUEST, REG_TONE_FREQ, 24'd0, 1'b1, 1'b1, 14'd9216, 14'd0, 1'b0},
    '{ROW_WRITE, REG_RATE, 24'd0, 1'b0, 1'b0, 14'd0, 14'd0, 1'b0},
    '{ROW_REQUEST, REG_TONE_FREQ, 24'd0, 1'b1, 1'b0, 14'd0, 14'd0, 1'b0},
    '{ROW_REQUEST, REG_TONE_FREQ, 24'd0, 1'b1, 1'b0, 14'd0, 14'd0, 1'b0},
    '{ROW_WRITE, REG_TONE_FREQ, 24'hFFFFFF, 1'b0, 1'b0, 14'd0, 14'd0, 1'b0},
    '{ROW_WRITE, REG_RATE, 24'hFFFFFF, 1'b0, 1'b0, 14'd0, 14'd0, 1'b0},
    '{ROW_REQUEST, REG_TONE_FREQ, 24'd0, 1'b1, 1'b0, 14'd0, 14'd0, 1'b0},
    '{ROW_REQUEST, REG_TONE_FREQ, 24'd0, 1'b1, 1'b0, 14'd0, 14'd0, 1'b0},
    '{ROW_REQUEST, REG_TONE_FREQ, 24'd0, 1'b1, 1'b0, 14'd0, 14'd0, 1'b0},
    '{ROW_REQUEST, REG_TONE_FREQ, 24'd0, 1'b1, 1'b0, 14'd0, 14'd0, 1'b0},
    '{ROW_WRITE, REG_RATE, 24'd3, 1'b0, 1'b0, 14'd0, 14'd0, 1'b0},
    '{ROW_REQUEST, REG_TONE_FREQ, 24'd0, 1'b1, 1'b0, 14'd0, 14'd0, 1'b0},
    '{ROW_REQUEST, REG_TONE_FREQ, 24'd0, 1'b1, 1'b0, 14'd0, 14'd0, 1'b0},
    '{ROW_WRITE, REG_TONE_FREQ, 24'd3, 1'b0, 1'b0, 14'd0, 14'd0, 1'b0},
    '{ROW_REQUEST, REG_TONE_FREQ, 24'd0, 1'b1, 1'b0, 14'd0, 14'd0, 1'b0},
    '{ROW_REQUEST, REG_TONE_FREQ, 24'd0, 1'b1, 1'b0, 14'd0, 14'd0, 1'b0},
    '{ROW_REQUEST, REG_TONE_FREQ, 24'd0, 1'b1, 1'b0, 14'd0, 14'd0, 1'b0},
    '{ROW_REQUEST, REG_TONE_FREQ, 24'd0, 1'b1, 1'b0, 14'd0, 14'd0, 1'b0},
    '{ROW_REQUEST, REG_TONE_FREQ, 24'd0, 1'b1, 1'b0, 14'd0, 14'd0, 1'b0},
    '{ROW_REQUEST, REG_TONE_FREQ, 24'd0, 1'b0, 1'b0, 14'd0, 14'd0, 1'b0}
  };

  iq_tone_generator #(
    .PHASE_BITS(PHASE_BITS),
    .PEAK_LEVEL(PEAK_LEVEL)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .push(push),
    .sample_request(sample_request),
    .full(full),
    .pop(pop),
    .empty(empty),
    .i_code(i_code),
    .q_code(q_code),
    .phase_restarted(phase_restarted)
  );

  always #2 clk = ~clk;

  function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] wide;
    wide = 128'(a) * 128'(b);
    return wide[123:60];
  endfunction

  function automatic int unsigned wave_entry(input int unsigned k);
    logic [127:0] wide;
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  term;
    logic [63:0]  acc;
    if (k == 0) begin
      return 0;
    end
    if (k >= QUARTER) begin
      return PEAK_LEVEL;
    end
    wide = 128'(HALF_PI_FX) * 128'(k);
    x = 64'(wide >> (PHASE_BITS - 2));
    x2 = fx_mul(x, x);
    term = x;
    acc = x;
    for (int n = 1; n <= 12; n++) begin
      term = fx_mul(term, x2) / 64'((2 * n) * (2 * n + 1));
      acc = n[0] ? acc - term : acc + term;
    end
    return int'(fx_mul(acc, 64'(PEAK_LEVEL)));
  endfunction

  function automatic logic [CODE_W-1:0] sine_word(input int unsigned angle);
    int unsigned quad;
    int unsigned r;
    int unsigned k;
    quad = (angle >> (PHASE_BITS - 2)) & 3;
    r = angle & (QUARTER - 1);
    k = quad[0] ? QUARTER - r : r;
    if (quad >= 2 && k != 0) begin
      return CODE_W'(NEG_BASE + quarter_wave[k]);
    end
    return CODE_W'(quarter_wave[k]);
  endfunction

  // advance the phase accumulator by one sample and return the pair
  function automatic iq_pair_t next_iq_pair();
    iq_pair_t    pair;
    logic [63:0] rate;
    logic [63:0] modulus;
    logic [63:0] p;
    int unsigned angle;
    rate = (rate_reg != 0) ? rate_reg : 64'd1;
    modulus = 4 * rate;
    p = phase_acc % modulus;
    angle = int'(((p % rate) << PHASE_BITS) / rate);
    pair.i_val = sine_word(angle);
    pair.q_val = sine_word((angle + QUARTER) & ((1 << PHASE_BITS) - 1));
    if (p == 0 && started) begin
      phase_acc = 64'd0;
      started = 1'b0;
      pair.restarted = 1'b1;
    end else begin
      phase_acc = (p + tone_step % modulus) % modulus;
      started = 1'b1;
      pair.restarted = 1'b0;
    end
    return pair;
  endfunction

  function automatic logic [CFG_W-1:0] pick_rate();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return CFG_W'(1);
      2: return CFG_W'($urandom_range(1, 16));
      3: return '1;
      4: return CFG_W'($urandom_range(1, 4096));
      default: return CFG_W'($urandom());
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_tone(input logic [CFG_W-1:0] rate);
    logic [CFG_W-1:0] r;
    r = (rate != 0) ? rate : CFG_W'(1);
    case ($urandom_range(0, 6))
      0: return '0;
      1: return '1;
      2: return CFG_W'(r * $urandom_range(1, 3));
      3: return CFG_W'($urandom_range(0, 3) * (r >> 2));
      4: return CFG_W'($urandom_range(0, 64));
      default: return CFG_W'($urandom());
    endcase
  endfunction

  initial begin
    for (int k = 0; k <= QUARTER; k++) begin
      quarter_wave[k] = wave_entry(k);
    end
  end

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_seen != hold_token) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // predict on accepted requesting words, compare on popped words
  always @(posedge clk) begin
    iq_pair_t want;
    if (!rst) begin
      if (pop && !empty) begin
        if (pending_pairs.size() == 0) begin
          $error("unexpected word: i %0d q %0d restarted %0d", i_code, q_code,
                 phase_restarted);
          mismatches++;
        end else begin
          want = pending_pairs.pop_front();
          if (i_code !== want.i_val) begin
            $error("i_code mismatch: expected %0d, got %0d", want.i_val, i_code);
            mismatches++;
          end
          if (q_code !== want.q_val) begin
            $error("q_code mismatch: expected %0d, got %0d", want.q_val, q_code);
            mismatches++;
          end
          if (phase_restarted !== want.restarted) begin
            $error("phase_restarted mismatch: expected %0d, got %0d", want.restarted,
                   phase_restarted);
            mismatches++;
          end
        end
      end
      if (cfg_write) begin
        if (cfg_index == REG_TONE_FREQ) begin
          tone_step = 64'(cfg_data);
        end else begin
          rate_reg = 64'(cfg_data);
        end
      end
      if (push && !full && sample_request) begin
        want = next_iq_pair();
        if (given) begin
          want = '{given_i, given_q, given_r};
        end
        pending_pairs.push_back(want);
      end
      if ((pop && !empty) || (push && !full) || cfg_write) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  task automatic send_word(input logic req, input logic typed,
                           input logic [CODE_W-1:0] ti, input logic [CODE_W-1:0] tq,
                           input logic tr);
    while ($urandom_range(0, 99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    sample_request <= req;
    given <= typed;
    given_i <= ti;
    given_q <= tq;
    given_r <= tr;
    do @(posedge clk); while (full);
  endtask

  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (pending_pairs.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [CFG_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [CFG_W-1:0] rate;
    int unsigned      sent;
    logic             req;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int n = 0; n < PLAN_LEN; n++) begin
      if (dir_plan[n].kind == ROW_WRITE) begin
        if (n == 0 || dir_plan[n-1].kind == ROW_REQUEST) begin
          drain();
        end
        write_reg(dir_plan[n].reg_sel, dir_plan[n].value);
      end else begin
        send_word(dir_plan[n].req, dir_plan[n].typed, dir_plan[n].i_val,
                  dir_plan[n].q_val, dir_plan[n].rst_val);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      rate = pick_rate();
      write_reg(REG_RATE, rate);
      write_reg(REG_TONE_FREQ, pick_tone(rate));
      case (ph % 4)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct = 59;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 59;
        end
        default: begin
          idle_pct = 7;
          stall_pct <= 7;
        end
      endcase
      if (ph == 4) begin
        hold_token <= hold_token + 1;
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (sent == PHASE_ITEMS / 2) begin
          // sender waits out every result, then the rate moves mid-stream
          drain();
          write_reg(REG_RATE, pick_rate());
          sent++;
        end else begin
          req = ($urandom_range(0, 9) != 0);
          send_word(req, 1'b0, '0, '0, 1'b0);
          if (req) begin
            sent++;
          end
        end
      end
    end

    drain();
    if (mismatches == 0 && pending_pairs.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
